### rtl/urb_pkg.sv
package urb_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;

    typedef enum logic [1:0] {
        FN_RX_BYTE  = 2'd0,
        FN_TX_DONE  = 2'd1,
        FN_WRITE    = 2'd2,
        FN_DRAIN    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TX_READ,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef logic [PTR_W-1:0] ptr_t;

    // circular increment, any depth
    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // bytes held between read and write pointer, saturated to the count width
    function automatic logic [COUNT_W-1:0] level_of(input ptr_t rd, input ptr_t wr);
        logic [PTR_W:0]         diff;
        logic [PTR_W+COUNT_W:0] wide;
        diff = {1'b0, wr} - {1'b0, rd};
        if (wr < rd)
        begin
            diff = diff + (PTR_W+1)'(QUEUE_DEPTH);
        end
        wide = (PTR_W+COUNT_W+1)'(diff);
        if (wide > (PTR_W+COUNT_W+1)'(2**COUNT_W - 1))
        begin
            return {COUNT_W{1'b1}};
        end
        return wide[COUNT_W-1:0];
    endfunction

endpackage

### rtl/urb_ram.sv
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/uart_rx_tx_ring_buffers.sv
// Receive and transmit byte queues for a serial port. Each input beat is one
// event (func): byte received, transmitter done, write byte, or drain the
// receive queue through the write rule. Each queue is a ring of QUEUE_DEPTH
// entries in its own RAM and holds at most QUEUE_DEPTH-1 bytes; a byte that
// finds its queue full is dropped and counted. Every event returns exactly
// one result beat with the byte handed to the transmitter (if any), the drop
// count and the busy mark and queue levels after the event. The block takes
// one event at a time: a byte received or a write goes through the execute
// and done steps before its result is registered, a transmitter done that
// pops a byte adds a RAM read step, and a drain walks its N receive-queue
// bytes, one queue entry per cycle through the shared write-rule logic. A
// result that is stalled holds the block in its final step; the next event
// can still be accepted while the previous result waits. No clearing pass is
// needed after reset.
module uart_rx_tx_ring_buffers
    import urb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [BYTE_W-1:0]   data_byte,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                send_valid,
    output logic [BYTE_W-1:0]   send_byte,
    output logic [COUNT_W-1:0]  dropped_count,
    output logic                tx_busy,
    output logic [COUNT_W-1:0]  rx_level,
    output logic [COUNT_W-1:0]  tx_level
);

    // sequencer
    state_t state_reg, state_next;

    // event being worked on
    func_t             func_reg, func_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    // queue pointers and transmitter busy mark
    ptr_t rx_rd_reg, rx_rd_next;
    ptr_t rx_wr_reg, rx_wr_next;
    ptr_t tx_rd_reg, tx_rd_next;
    ptr_t tx_wr_reg, tx_wr_next;
    logic busy_reg, busy_next;

    // per-event result accumulators
    logic               sent_reg, sent_next;
    logic [BYTE_W-1:0]  sbyte_reg, sbyte_next;
    logic [COUNT_W-1:0] drop_reg, drop_next;

    // output beat register
    logic               ovalid_reg, ovalid_next;
    logic               osend_reg, osend_next;
    logic [BYTE_W-1:0]  obyte_reg, obyte_next;
    logic [COUNT_W-1:0] odrop_reg, odrop_next;
    logic               obusy_reg, obusy_next;
    logic [COUNT_W-1:0] orx_reg, orx_next;
    logic [COUNT_W-1:0] otx_reg, otx_next;

    // ram ports
    logic              rx_we, tx_we;
    ptr_t              rx_waddr, rx_raddr, tx_waddr, tx_raddr;
    logic [BYTE_W-1:0] rx_wdata, tx_wdata, rx_rdata, tx_rdata;

    logic              in_accept;
    logic              out_free;
    logic              do_rule;
    logic [BYTE_W-1:0] rule_byte;
    logic              rx_full, tx_full, rx_empty, tx_empty;
    ptr_t              rx_rd_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !ovalid_reg || !out_stall;

    assign rx_full   = (next_ptr(rx_wr_reg) == rx_rd_reg);
    assign tx_full   = (next_ptr(tx_wr_reg) == tx_rd_reg);
    assign rx_empty  = (rx_rd_reg == rx_wr_reg);
    assign tx_empty  = (tx_rd_reg == tx_wr_reg);
    assign rx_rd_inc = next_ptr(rx_rd_reg);

    urb_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    urb_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    FN_TX_DONE: state_next = tx_empty ? S_DONE : S_TX_READ;
                    FN_DRAIN:   state_next = rx_empty ? S_DONE : S_DRAIN;
                    default:    state_next = S_DONE;
                endcase
            end
            S_TX_READ:
            begin
                state_next = S_DONE;
            end
            S_DRAIN:
            begin
                // last entry consumed this cycle
                if (rx_rd_inc == rx_wr_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        func_next   = func_reg;
        data_next   = data_reg;
        rx_rd_next  = rx_rd_reg;
        rx_wr_next  = rx_wr_reg;
        tx_rd_next  = tx_rd_reg;
        tx_wr_next  = tx_wr_reg;
        busy_next   = busy_reg;
        sent_next   = sent_reg;
        sbyte_next  = sbyte_reg;
        drop_next   = drop_reg;

        ovalid_next = ovalid_reg && out_stall;
        osend_next  = osend_reg;
        obyte_next  = obyte_reg;
        odrop_next  = odrop_reg;
        obusy_next  = obusy_reg;
        orx_next    = orx_reg;
        otx_next    = otx_reg;

        rx_we       = 1'b0;
        rx_waddr    = rx_wr_reg;
        rx_wdata    = data_reg;
        rx_raddr    = rx_rd_reg;
        tx_we       = 1'b0;
        tx_waddr    = tx_wr_reg;
        tx_wdata    = data_reg;
        tx_raddr    = tx_rd_reg;

        do_rule     = 1'b0;
        rule_byte   = data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next  = func_t'(func);
                    data_next  = data_byte;
                    sent_next  = 1'b0;
                    sbyte_next = '0;
                    drop_next  = '0;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    FN_RX_BYTE:
                    begin
                        if (rx_full)
                        begin
                            drop_next = COUNT_W'(1);
                        end
                        else
                        begin
                            rx_we      = 1'b1;
                            rx_wr_next = next_ptr(rx_wr_reg);
                        end
                    end
                    FN_TX_DONE:
                    begin
                        // nonempty: read issued here, data taken next cycle
                        if (tx_empty)
                        begin
                            busy_next = 1'b0;
                        end
                    end
                    FN_WRITE:
                    begin
                        do_rule = 1'b1;
                    end
                    default:
                    begin
                        // drain: first read issued at rx_rd
                    end
                endcase
            end
            S_TX_READ:
            begin
                sent_next  = 1'b1;
                sbyte_next = tx_rdata;
                tx_rd_next = next_ptr(tx_rd_reg);
            end
            S_DRAIN:
            begin
                do_rule    = 1'b1;
                rule_byte  = rx_rdata;
                rx_rd_next = rx_rd_inc;
                rx_raddr   = rx_rd_inc;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    osend_next  = sent_reg;
                    obyte_next  = sbyte_reg;
                    odrop_next  = drop_reg;
                    obusy_next  = busy_reg;
                    orx_next    = level_of(rx_rd_reg, rx_wr_reg);
                    otx_next    = level_of(tx_rd_reg, tx_wr_reg);
                end
            end
            default:
            begin
            end
        endcase

        // write rule: straight to an idle transmitter, else queue or drop
        if (do_rule)
        begin
            if (busy_reg)
            begin
                if (tx_full)
                begin
                    if (drop_reg != {COUNT_W{1'b1}})
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                end
                else
                begin
                    tx_we      = 1'b1;
                    tx_wdata   = rule_byte;
                    tx_wr_next = next_ptr(tx_wr_reg);
                end
            end
            else
            begin
                sent_next  = 1'b1;
                sbyte_next = rule_byte;
                busy_next  = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rx_rd_reg  <= '0;
            rx_wr_reg  <= '0;
            tx_rd_reg  <= '0;
            tx_wr_reg  <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rx_rd_reg  <= rx_rd_next;
            rx_wr_reg  <= rx_wr_next;
            tx_rd_reg  <= tx_rd_next;
            tx_wr_reg  <= tx_wr_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        data_reg  <= data_next;
        sent_reg  <= sent_next;
        sbyte_reg <= sbyte_next;
        drop_reg  <= drop_next;
        osend_reg <= osend_next;
        obyte_reg <= obyte_next;
        odrop_reg <= odrop_next;
        obusy_reg <= obusy_next;
        orx_reg   <= orx_next;
        otx_reg   <= otx_next;
    end

    assign out_valid     = ovalid_reg;
    assign send_valid    = osend_reg;
    assign send_byte     = obyte_reg;
    assign dropped_count = odrop_reg;
    assign tx_busy       = obusy_reg;
    assign rx_level      = orx_reg;
    assign tx_level      = otx_reg;

    // an idle transmitter never has bytes waiting
    a_idle_tx_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> tx_empty)
        else $error("transmit queue holds bytes while transmitter idle");

    // no write into a full queue
    a_rx_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rx_we |-> !rx_full)
        else $error("receive queue written while full");

    a_tx_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        tx_we |-> !tx_full)
        else $error("transmit queue written while full");

    // drain only walks entries that are really there
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> !rx_empty)
        else $error("drain step on empty receive queue");

    // a drain leaves the receive queue empty
    a_drain_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && func_reg == FN_DRAIN) |-> rx_empty)
        else $error("receive queue not empty after drain");

endmodule
